// ===== sv/cpmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmt_pkg
// Shared types and constants of the contact pressure metric table: field
// widths, the per-peer row layout and the divider request and response.
// ----------------------------------------------------------------------------
package cpmt_pkg;

	// table size and address width
	localparam int PEERS  = 64;
	localparam int ADDR_W = $clog2(PEERS);

	// field widths
	localparam int KIND_W   = 2;
	localparam int PEER_W   = 6;
	localparam int TIME_W   = 32;
	localparam int SUM_W    = 64;
	localparam int METRIC_W = 56;
	localparam int WEIGHT_W = 49;
	localparam int OPEN_W   = 8;

	// metric = sum * 2^8 / (2 * t) = sum * 2^7 / t
	localparam int FRAC_SHIFT   = 7;
	localparam int DIVIDEND_W   = SUM_W + FRAC_SHIFT;
	localparam int DIVISOR_W    = METRIC_W;
	localparam int METRIC_ITERS = DIVIDEND_W;
	// weight = 2^48 / metric, a 49-bit dividend
	localparam int WEIGHT_ITERS = WEIGHT_W;
	localparam int CNT_W        = $clog2(DIVIDEND_W + 1);

	localparam logic [METRIC_W-1:0] METRIC_MAX = {METRIC_W{1'b1}};
	localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};

	localparam logic signed [OPEN_W-1:0] OPEN_MAX = {1'b0, {(OPEN_W-1){1'b1}}};
	localparam logic signed [OPEN_W-1:0] OPEN_MIN = {1'b1, {(OPEN_W-1){1'b0}}};
	localparam logic signed [OPEN_W-1:0] OPEN_ONE = {{(OPEN_W-1){1'b0}}, 1'b1};

	// request kinds; the unused code acts as a query
	typedef enum logic [KIND_W-1:0] {
		KIND_UP    = 2'd0,
		KIND_DOWN  = 2'd1,
		KIND_QUERY = 2'd2
	} kind_t;

	// one table row per peer
	typedef struct packed {
		logic signed [OPEN_W-1:0] open_cnt;
		logic [TIME_W-1:0]        last_end;
		logic [SUM_W-1:0]         gap_sum;
		logic [METRIC_W-1:0]      metric;
		logic                     metric_ok;
	} row_t;

	// divider request and response
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
		logic [CNT_W-1:0]      iters;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIVISOR_W-1:0] quotient;
		logic                 overflow;
	} div_rsp_t;

	// table address of a peer index
	function automatic logic [ADDR_W-1:0] peer_addr(input logic [PEER_W-1:0] p);
		logic [ADDR_W+PEER_W-1:0] wide;
		wide = {{ADDR_W{1'b0}}, p};
		return wide[ADDR_W-1:0];
	endfunction

	// peer index inside the table
	function automatic logic peer_in_range(input logic [PEER_W-1:0] p);
		logic [ADDR_W+PEER_W:0] wide;
		wide = {{(ADDR_W+1){1'b0}}, p};
		return wide < (ADDR_W+PEER_W+1)'(PEERS);
	endfunction

endpackage

// ===== sv/contact_pressure_metric_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contact_pressure_metric_table
// Per-peer contact pressure metric: open-contact count, last contact end,
// saturating sum of squared gaps and metric = sum / (2 * time), with weight.
// ----------------------------------------------------------------------------
// One request is worked at a time and in_stall stays high from acceptance
// until its result is moved into the result register. Both divisions run on
// the single shared radix-2 divider, which yields one quotient bit per cycle.
// A query, or a contact event that leaves the metric as it is, runs a table
// read, the weight start, the weight division, a step to see completion and
// the load, or only the read, the weight start and the load when the metric
// is unknown or zero and no weight is divided. A contact down that recomputes
// the metric adds the metric quotient before the weight, and a contact up
// that recomputes it adds the squared gap and the sum before that; each
// division has a start step and a completion step. When the new metric is
// zero the weight division is skipped. A held out_stall with a result still
// waiting holds back the load. The next request is taken in the cycle after
// the load at the earliest. The result register frees the input side, so the
// next request is taken while a result still waits on out_stall. Rows are
// cleared by per-entry flags at reset; there is no clearing pass and the
// block is ready right after reset.
// ----------------------------------------------------------------------------
module contact_pressure_metric_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [cpmt_pkg::KIND_W-1:0]       kind,
	input  logic [cpmt_pkg::PEER_W-1:0]       peer,
	input  logic [cpmt_pkg::TIME_W-1:0]       now_ticks,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              metric_known,
	output logic [cpmt_pkg::METRIC_W-1:0]     metric_value,
	output logic [cpmt_pkg::WEIGHT_W-1:0]     weight,
	output logic signed [cpmt_pkg::OPEN_W-1:0] open_contacts
);
	import cpmt_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_READ   = 9'b000000010,
		ST_MUL    = 9'b000000100,
		ST_ACC    = 9'b000001000,
		ST_MSTART = 9'b000010000,
		ST_DIVM   = 9'b000100000,
		ST_WSTART = 9'b001000000,
		ST_DIVW   = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t state_q;

	// request and working row
	kind_t               kind_q;
	logic [PEER_W-1:0]   peer_q;
	logic [TIME_W-1:0]   now_q;
	row_t                row_q;
	logic [TIME_W-1:0]   gap_q;
	logic [SUM_W-1:0]    sq_q;
	logic [WEIGHT_W-1:0] weight_q;

	// result register
	logic                       out_valid_q;
	logic                       known_q;
	logic [METRIC_W-1:0]        metric_q;
	logic [WEIGHT_W-1:0]        weight_out_q;
	logic signed [OPEN_W-1:0]   open_q;

	logic                       accept;
	logic                       in_range;
	logic                       out_load;
	logic                       weight_go;
	row_t                       rd_row;
	row_t                       row_rd;
	logic signed [OPEN_W-1:0]   open_up;
	logic signed [OPEN_W-1:0]   open_dn;
	logic [TIME_W-1:0]          gap_d;
	logic [SUM_W-1:0]           sq_d;
	logic [SUM_W:0]             acc_d;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_range  = peer_in_range(peer_q);
	assign weight_go = row_q.metric_ok && (row_q.metric != '0);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// per-peer row storage
	cpmt_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (peer_addr(peer)),
		.wr_en   ((state_q == ST_WSTART) && in_range),
		.wr_addr (peer_addr(peer_q)),
		.wr_row  (row_q),
		.rd_row  (rd_row)
	);

	// shared divider
	cpmt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// saturating open count steps and the gap to the last contact end
	always_comb begin
		open_up = (rd_row.open_cnt != OPEN_MAX) ? rd_row.open_cnt + OPEN_ONE
		                                        : rd_row.open_cnt;
		open_dn = (rd_row.open_cnt != OPEN_MIN) ? rd_row.open_cnt - OPEN_ONE
		                                        : rd_row.open_cnt;
		gap_d   = (now_q >= rd_row.last_end) ? now_q - rd_row.last_end
		                                     : rd_row.last_end - now_q;
		sq_d    = SUM_W'(gap_q) * SUM_W'(gap_q);
		acc_d   = {1'b0, row_q.gap_sum} + {1'b0, sq_q};
	end

	// row after the open count step of the request
	always_comb begin
		row_rd = rd_row;
		if (!in_range) begin
			row_rd = '0;
		end else begin
			case (kind_q)
				KIND_UP: row_rd.open_cnt = open_up;
				KIND_DOWN: begin
					row_rd.open_cnt = open_dn;
					if (open_dn == '0) row_rd.last_end = now_q;
				end
				default: row_rd.open_cnt = rd_row.open_cnt;
			endcase
		end
	end

	// divider requests
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_MSTART: begin
				div_req.start    = 1'b1;
				div_req.dividend = {row_q.gap_sum, {FRAC_SHIFT{1'b0}}};
				div_req.divisor  = {{(DIVISOR_W-TIME_W){1'b0}}, now_q};
				div_req.iters    = CNT_W'(METRIC_ITERS);
			end
			ST_WSTART: begin
				div_req.start    = weight_go;
				div_req.dividend = {1'b1, {(DIVIDEND_W-1){1'b0}}};
				div_req.divisor  = row_q.metric;
				div_req.iters    = CNT_W'(WEIGHT_ITERS);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_READ;
				end
				ST_READ: begin
					if (!in_range) begin
						state_q <= ST_WSTART;
					end else begin
						case (kind_q)
							KIND_UP: begin
								if ((open_up <= OPEN_ONE) && (now_q != '0)) state_q <= ST_MUL;
								else state_q <= ST_WSTART;
							end
							KIND_DOWN: begin
								if ((open_dn == '0) && (now_q != '0)) state_q <= ST_MSTART;
								else state_q <= ST_WSTART;
							end
							default: state_q <= ST_WSTART;
						endcase
					end
				end
				ST_MUL:    state_q <= ST_ACC;
				ST_ACC:    state_q <= ST_MSTART;
				ST_MSTART: state_q <= ST_DIVM;
				ST_DIVM: begin
					if (div_rsp.done) state_q <= ST_WSTART;
				end
				ST_WSTART: begin
					if (weight_go) state_q <= ST_DIVW;
					else state_q <= ST_DONE;
				end
				ST_DIVW: begin
					if (div_rsp.done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working row and arithmetic registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q <= kind_t'(kind);
					peer_q <= peer;
					now_q  <= now_ticks;
				end
			end
			ST_READ: begin
				gap_q <= gap_d;
				row_q <= row_rd;
			end
			ST_MUL: sq_q <= sq_d;
			ST_ACC: row_q.gap_sum <= acc_d[SUM_W] ? SUM_MAX : acc_d[SUM_W-1:0];
			ST_DIVM: begin
				if (div_rsp.done) begin
					{row_q.metric, row_q.metric_ok} <=
						{div_rsp.overflow ? METRIC_MAX : div_rsp.quotient, 1'b1};
				end
			end
			ST_WSTART: begin
				if (!weight_go) weight_q <= '0;
			end
			ST_DIVW: begin
				if (div_rsp.done) weight_q <= div_rsp.quotient[WEIGHT_W-1:0];
			end
			default: begin
				gap_q <= gap_q;
			end
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			known_q      <= row_q.metric_ok;
			metric_q     <= row_q.metric;
			weight_out_q <= weight_q;
			open_q       <= row_q.open_cnt;
		end
	end

	assign out_valid     = out_valid_q;
	assign metric_known  = known_q;
	assign metric_value  = metric_q;
	assign weight        = weight_out_q;
	assign open_contacts = open_q;

`ifndef ASSERT_OFF
	// a nonzero weight only comes from a known metric
	a_weight_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (weight != '0) |-> metric_known)
		else $error("weight reported for an unknown metric");

	// an unknown metric reads as zero
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !metric_known |-> (metric_value == '0) && (weight == '0))
		else $error("unknown metric reported with nonzero value");

	// while waiting on a quotient the divider is running or finishing
	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVM) || (state_q == ST_DIVW) |-> div_rsp.busy || div_rsp.done)
		else $error("sequencer waits on an idle divider");
`endif

endmodule

// ===== sv/cpmt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmt_div
// Shared radix-2 restoring divider, one quotient bit per cycle. Keeps the
// low quotient bits and a sticky flag for any set bit shifted out above them.
// ----------------------------------------------------------------------------
module cpmt_div (
	input  logic                clk,
	input  logic                arst_n,
	input  cpmt_pkg::div_req_t  req,
	output cpmt_pkg::div_rsp_t  rsp
);
	import cpmt_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  quo_q;
	logic                  ovf_q;

	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W+1:0]  diff;
	logic                  ge;

	// trial subtract of the divisor from the shifted remainder
	always_comb begin
		shifted = {rem_q, dvd_q[DIVIDEND_W-1]};
		diff    = {1'b0, shifted} - {2'b00, dsr_q};
		ge      = ~diff[DIVISOR_W+1];
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVISOR_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[DIVISOR_W-1];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
	assign rsp.overflow = ovf_q;

`ifndef ASSERT_OFF
	// a new division never cuts into a running one
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	// completion follows a running division
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	// a start always leads into the running state
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		req.start && (req.iters != '0) |=> busy_q)
		else $error("divider did not start");
`endif

endmodule

// ===== sv/cpmt_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpmt_table
// Per-peer row memory with a registered read port. A row-written bit per
// entry makes rows that were never written read as all zero after reset.
// ----------------------------------------------------------------------------
module cpmt_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [cpmt_pkg::ADDR_W-1:0]   rd_addr,
	input  logic                          wr_en,
	input  logic [cpmt_pkg::ADDR_W-1:0]   wr_addr,
	input  cpmt_pkg::row_t                wr_row,
	output cpmt_pkg::row_t                rd_row
);
	import cpmt_pkg::*;

	row_t             mem [PEERS];
	row_t             rd_data_q;
	logic             rd_vld_q;
	logic [PEERS-1:0] row_vld_q;

	// row-written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_row = rd_vld_q ? rd_data_q : '0;

endmodule
